// ===== hdl/mnp_pkg.sv =====
package mnp_pkg;

    localparam int KEY_W         = 7;
    localparam int VEL_W         = 7;
    localparam int NUM_KEYS_DEF  = 128;
    localparam int MN_W          = 10;

    localparam logic [KEY_W-1:0] NOTE_TOP = 7'd127;

    localparam logic [1:0] MODE_NOTE_OFF = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_ALL_OFF  = 2'd2;

    localparam logic [1:0] PRIO_OFF  = 2'd0;
    localparam logic [1:0] PRIO_LOW  = 2'd1;
    localparam logic [1:0] PRIO_HIGH = 2'd2;

    localparam logic [1:0] CFG_PRIORITY_MODE    = 2'd0;
    localparam logic [1:0] CFG_RETRIGGER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_LEGATO_VELOCITY  = 2'd2;
    localparam logic [1:0] CFG_TRANSPOSE        = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_FOLD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             note_valid;
        logic [KEY_W-1:0] note;
        logic             gate_on;
        logic             retrigger;
        logic             key_off;
        logic             velocity_update;
        logic [VEL_W-1:0] velocity_out;
    } voice_t;

    typedef struct packed {
        logic             clear;
        logic             held_we;
        logic             held_val;
        logic             vel_we;
        logic [KEY_W-1:0] key;
        logic [VEL_W-1:0] velocity;
        logic [KEY_W-1:0] scan_idx;
        logic [KEY_W-1:0] rd_addr;
    } map_ctrl_t;

endpackage

// ===== hdl/mnp_event_if.sv =====
interface mnp_event_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [mnp_pkg::KEY_W-1:0]   key;
    logic [mnp_pkg::VEL_W-1:0]   velocity;
    logic                        hold_pedal;

    modport source (output valid, mode, key, velocity, hold_pedal, input ready);
    modport sink   (input valid, mode, key, velocity, hold_pedal, output ready);
endinterface

// ===== hdl/mnp_voice_if.sv =====
interface mnp_voice_if;
    logic                        valid;
    logic                        ready;
    logic                        note_valid;
    logic [mnp_pkg::KEY_W-1:0]   note;
    logic                        gate_on;
    logic                        retrigger;
    logic                        key_off;
    logic                        velocity_update;
    logic [mnp_pkg::VEL_W-1:0]   velocity_out;

    modport source (output valid, note_valid, note, gate_on, retrigger, key_off,
                    velocity_update, velocity_out, input ready);
    modport sink   (input valid, note_valid, note, gate_on, retrigger, key_off,
                    velocity_update, velocity_out, output ready);
endinterface

// ===== hdl/mnp_key_map.sv =====
module mnp_key_map #(
    parameter int NUM_KEYS = mnp_pkg::NUM_KEYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mnp_pkg::map_ctrl_t        ctrl,
    output logic                      scan_held,
    output logic [mnp_pkg::VEL_W-1:0] rd_velocity
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0]      held_reg;
    logic [mnp_pkg::VEL_W-1:0] vel_mem [NUM_KEYS];
    logic [mnp_pkg::VEL_W-1:0] rd_velocity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            held_reg <= '0;
        end
        else if (ctrl.held_we)
        begin
            held_reg[ctrl.key[IDX_W-1:0]] <= ctrl.held_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.vel_we)
        begin
            vel_mem[ctrl.key[IDX_W-1:0]] <= ctrl.velocity;
        end
        rd_velocity_reg <= vel_mem[ctrl.rd_addr[IDX_W-1:0]];
    end

    assign scan_held   = held_reg[ctrl.scan_idx[IDX_W-1:0]];
    assign rd_velocity = rd_velocity_reg;

endmodule

// ===== hdl/mono_note_priority_unit.sv =====
// Monophonic note priority for one voice. Each note on or note off event,
// but for those named below that skip the walk, updates the held-key map,
// then the map is walked one key per cycle to count held keys and find the
// lowest and highest. An event passes through accept, the map walk, select,
// the add-or-subtract-12 octave fold and result, in that order. An event
// that reports no note (key off, or a key away from the favored end) skips
// the fold. All-notes-off, the unused mode code, events with priority_mode
// off and keys at or above NUM_KEYS go straight from accept to result. The
// event input is not ready until the result has been loaded into the output
// register, so a stalled output holds off the next event; one result is
// produced per event.
module mono_note_priority_unit #(
    parameter int NUM_KEYS = mnp_pkg::NUM_KEYS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [7:0]               cfg_data,
    mnp_event_if.sink                midi,
    mnp_voice_if.source              voice
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNT_W = $clog2(NUM_KEYS + 1);

    mnp_pkg::state_t state_reg, state_next;

    logic [1:0]              prio_reg;
    logic                    retrig_en_reg;
    logic                    legato_reg;
    logic signed [7:0]       transpose_reg;

    logic                    is_on_reg, is_on_next;
    logic [mnp_pkg::KEY_W-1:0] key_reg, key_next;
    logic [mnp_pkg::VEL_W-1:0] vel_reg, vel_next;
    logic                    pedal_reg, pedal_next;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [mnp_pkg::KEY_W-1:0] low_reg, low_next;
    logic [mnp_pkg::KEY_W-1:0] high_reg, high_next;
    logic [mnp_pkg::KEY_W-1:0] extreme_reg, extreme_next;
    logic [mnp_pkg::KEY_W-1:0] sel_reg, sel_next;
    logic signed [mnp_pkg::MN_W-1:0] mn_reg, mn_next;
    logic                    use_mem_reg, use_mem_next;

    mnp_pkg::voice_t         res_reg, res_next;
    mnp_pkg::voice_t         out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    mnp_pkg::map_ctrl_t      map_ctrl;
    logic                    scan_held;
    logic [mnp_pkg::VEL_W-1:0] rd_velocity;

    logic                    accept;
    logic                    trivial;
    logic                    scan_last;
    logic                    fold_done;
    logic                    out_free;
    logic                    early_done;
    logic [mnp_pkg::KEY_W-1:0] ext_sel;
    logic [mnp_pkg::KEY_W-1:0] sel_val;
    logic                    favored;

    mnp_key_map #(
        .NUM_KEYS (NUM_KEYS)
    ) u_key_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (map_ctrl),
        .scan_held   (scan_held),
        .rd_velocity (rd_velocity)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg      <= mnp_pkg::PRIO_OFF;
            retrig_en_reg <= 1'b0;
            legato_reg    <= 1'b0;
            transpose_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mnp_pkg::CFG_PRIORITY_MODE:    prio_reg      <= cfg_data[1:0];
                mnp_pkg::CFG_RETRIGGER_ENABLE: retrig_en_reg <= cfg_data[0];
                mnp_pkg::CFG_LEGATO_VELOCITY:  legato_reg    <= cfg_data[0];
                mnp_pkg::CFG_TRANSPOSE:        transpose_reg <= $signed(cfg_data);
                default:                       prio_reg      <= prio_reg;
            endcase
        end
    end

    // decode
    always_comb
    begin
        accept    = midi.valid && (state_reg == mnp_pkg::ST_IDLE);
        trivial   = !(midi.mode == mnp_pkg::MODE_NOTE_OFF || midi.mode == mnp_pkg::MODE_NOTE_ON)
                    || !(prio_reg == mnp_pkg::PRIO_LOW || prio_reg == mnp_pkg::PRIO_HIGH)
                    || ({1'b0, midi.key} >= 8'(NUM_KEYS));
        scan_last = (idx_reg == IDX_W'(NUM_KEYS - 1));
        fold_done = (mn_reg >= $signed(10'sd0)) && (mn_reg <= $signed(10'sd127));
        out_free  = !out_valid_reg || voice.ready;

        if (prio_reg == mnp_pkg::PRIO_LOW)
        begin
            ext_sel = ((extreme_reg == '0) || (extreme_reg < high_reg)) ? high_reg : extreme_reg;
            favored = !(key_reg > low_reg);
            sel_val = low_reg;
        end
        else
        begin
            ext_sel = ((extreme_reg == '0) || (extreme_reg > low_reg)) ? low_reg : extreme_reg;
            favored = !(key_reg < high_reg);
            sel_val = high_reg;
        end
        if (cnt_reg == '0)
        begin
            sel_val = ext_sel;
        end
        early_done = ((cnt_reg == '0) && !pedal_reg) || !favored;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mnp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = trivial ? mnp_pkg::ST_FINISH : mnp_pkg::ST_SCAN;
                end
            end
            mnp_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = mnp_pkg::ST_SELECT;
                end
            end
            mnp_pkg::ST_SELECT:
            begin
                state_next = early_done ? mnp_pkg::ST_FINISH : mnp_pkg::ST_FOLD;
            end
            mnp_pkg::ST_FOLD:
            begin
                if (fold_done)
                begin
                    state_next = mnp_pkg::ST_FINISH;
                end
            end
            mnp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mnp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        midi.ready     = (state_reg == mnp_pkg::ST_IDLE);

        is_on_next     = is_on_reg;
        key_next       = key_reg;
        vel_next       = vel_reg;
        pedal_next     = pedal_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        extreme_next   = extreme_reg;
        sel_next       = sel_reg;
        mn_next        = mn_reg;
        use_mem_next   = use_mem_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (voice.ready)
        begin
            out_valid_next = 1'b0;
        end

        map_ctrl          = '0;
        map_ctrl.key      = midi.key;
        map_ctrl.velocity = midi.velocity;
        map_ctrl.held_val = (midi.mode == mnp_pkg::MODE_NOTE_ON);
        map_ctrl.scan_idx = mnp_pkg::KEY_W'(idx_reg);
        map_ctrl.rd_addr  = sel_reg;

        case (state_reg)
            mnp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    map_ctrl.clear   = (midi.mode == mnp_pkg::MODE_ALL_OFF);
                    map_ctrl.held_we = !trivial;
                    map_ctrl.vel_we  = !trivial && (midi.mode == mnp_pkg::MODE_NOTE_ON);
                    is_on_next   = (midi.mode == mnp_pkg::MODE_NOTE_ON);
                    key_next     = midi.key;
                    vel_next     = midi.velocity;
                    pedal_next   = midi.hold_pedal;
                    idx_next     = '0;
                    cnt_next     = '0;
                    low_next     = mnp_pkg::NOTE_TOP;
                    high_next    = '0;
                    use_mem_next = 1'b0;
                    res_next     = '0;
                end
            end
            mnp_pkg::ST_SCAN:
            begin
                if (scan_held)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    high_next = mnp_pkg::KEY_W'(idx_reg);
                    if (cnt_reg == '0)
                    begin
                        low_next = mnp_pkg::KEY_W'(idx_reg);
                    end
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            mnp_pkg::ST_SELECT:
            begin
                extreme_next = ext_sel;
                sel_next     = sel_val;
                mn_next      = $signed({3'b000, sel_val}) + mnp_pkg::MN_W'(transpose_reg);
                res_next     = '0;
                if ((cnt_reg == '0) && !pedal_reg)
                begin
                    res_next.key_off = 1'b1;
                end
                else if (favored)
                begin
                    res_next.note_valid = 1'b1;
                    if (is_on_reg)
                    begin
                        if (cnt_reg == CNT_W'(1))
                        begin
                            res_next.gate_on         = 1'b1;
                            res_next.retrigger       = 1'b1;
                            res_next.velocity_update = 1'b1;
                            res_next.velocity_out    = vel_reg;
                        end
                        else
                        begin
                            res_next.retrigger       = retrig_en_reg;
                            res_next.velocity_update = !legato_reg;
                            res_next.velocity_out    = legato_reg ? '0 : vel_reg;
                        end
                    end
                    else
                    begin
                        res_next.retrigger       = retrig_en_reg;
                        res_next.velocity_update = retrig_en_reg && !legato_reg;
                        use_mem_next             = retrig_en_reg && !legato_reg;
                    end
                end
            end
            mnp_pkg::ST_FOLD:
            begin
                if (mn_reg > $signed(10'sd127))
                begin
                    mn_next = mn_reg - $signed(10'sd12);
                end
                else if (mn_reg < $signed(10'sd0))
                begin
                    mn_next = mn_reg + $signed(10'sd12);
                end
                else
                begin
                    res_next.note = mn_reg[mnp_pkg::KEY_W-1:0];
                end
            end
            mnp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    if (use_mem_reg)
                    begin
                        out_next.velocity_out = rd_velocity;
                    end
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mnp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            extreme_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            extreme_reg   <= extreme_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_on_reg   <= is_on_next;
        key_reg     <= key_next;
        vel_reg     <= vel_next;
        pedal_reg   <= pedal_next;
        idx_reg     <= idx_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        sel_reg     <= sel_next;
        mn_reg      <= mn_next;
        use_mem_reg <= use_mem_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign voice.valid           = out_valid_reg;
    assign voice.note_valid      = out_reg.note_valid;
    assign voice.note            = out_reg.note;
    assign voice.gate_on         = out_reg.gate_on;
    assign voice.retrigger       = out_reg.retrigger;
    assign voice.key_off         = out_reg.key_off;
    assign voice.velocity_update = out_reg.velocity_update;
    assign voice.velocity_out    = out_reg.velocity_out;

endmodule
